FILE: src/lav_pkg.sv
// Shared types, widths and helper functions for the look-at view matrix block.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package lav_pkg;

   localparam int IN_W   = 32;
   localparam int PM_W   = 30;
   localparam int FW     = PM_W + 1;
   localparam int VW     = 2 * FW;
   localparam int RT_W   = 31;
   localparam int SQ_W   = 64;
   localparam int ELEM_W = 18;

   typedef enum logic [1:0] {
      ROW_RIGHT = 2'd0,
      ROW_UP    = 2'd1,
      ROW_FWD   = 2'd2
   } row_type;

   typedef logic [PM_W-1:0] mag_type;

   typedef struct packed {
      row_type                 row;
      logic                    degen;
      logic [2:0]              neg;
      logic signed [IN_W-1:0]  pos_x;
      logic signed [IN_W-1:0]  pos_y;
      logic signed [IN_W-1:0]  pos_z;
   } side_type;

   function automatic logic [4:0] lead32(input logic [31:0] v);
      logic [4:0] p;
      p = '0;
      for (int i = 0; i < 32; i++) begin
         if (v[i]) p = 5'(i);
      end
      return p;
   endfunction

   function automatic logic [5:0] lead62(input logic [VW-1:0] v);
      logic [5:0] p;
      p = '0;
      for (int i = 0; i < VW; i++) begin
         if (v[i]) p = 6'(i);
      end
      return p;
   endfunction

endpackage

FILE: src/lav_prep.sv
// Front pipeline: forward axis prescale, up-axis products, row vector select
// and prescale of the selected vector. Depends on lav_pkg.
`timescale 1ns / 1ps

module lav_prep (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic                    in_valid,
   input  lav_pkg::side_type       in_side,
   input  logic signed [31:0]      view_x,
   input  logic signed [31:0]      view_y,
   input  logic signed [31:0]      view_z,
   output logic                    out_valid,
   output lav_pkg::side_type       out_side,
   output lav_pkg::mag_type        out_mag [3]
);
   import lav_pkg::*;

   function automatic logic [VW-1:0] abs_v(input logic signed [VW-1:0] v);
      return v[VW-1] ? VW'(-v) : VW'(v);
   endfunction

   // stage A: magnitudes of the negated view
   logic [31:0] vin [3];
   logic [31:0] a_mag_in [3];
   logic [2:0]  a_neg_in;
   logic [4:0]  a_lead_in;
   logic        a_valid_ff;
   side_type    a_side_ff;
   logic [31:0] a_mag_ff [3];
   logic [2:0]  a_neg_ff;
   logic [4:0]  a_lead_ff;

   always_comb begin
      vin[0] = view_x;
      vin[1] = view_y;
      vin[2] = view_z;
      for (int i = 0; i < 3; i++) begin
         a_mag_in[i] = vin[i][31] ? (~vin[i] + 32'd1) : vin[i];
         a_neg_in[i] = !vin[i][31] && (vin[i] != '0);
      end
      a_lead_in = lead32(a_mag_in[0] | a_mag_in[1] | a_mag_in[2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_side_ff <= in_side;
         a_mag_ff  <= a_mag_in;
         a_neg_ff  <= a_neg_in;
         a_lead_ff <= a_lead_in;
      end
   end

   // stage B: shift forward axis into range
   mag_type              b_mag_in [3];
   logic signed [FW-1:0] b_f_in [3];
   side_type             b_side_in;
   logic                 b_valid_ff;
   side_type             b_side_ff;
   logic signed [FW-1:0] b_f_ff [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (a_lead_ff >= 5'd29) begin
            b_mag_in[i] = PM_W'(a_mag_ff[i] >> (a_lead_ff - 5'd29));
         end else begin
            b_mag_in[i] = PM_W'(a_mag_ff[i] << (5'd29 - a_lead_ff));
         end
         b_f_in[i] = a_neg_ff[i] ? -$signed({1'b0, b_mag_in[i]}) : $signed({1'b0, b_mag_in[i]});
      end
      b_side_in       = a_side_ff;
      b_side_in.degen = (b_mag_in[0] == '0) && (b_mag_in[2] == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (en) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b_side_ff <= b_side_in;
         b_f_ff    <= b_f_in;
      end
   end

   // stage C: products for the up axis
   logic                 c_valid_ff;
   side_type             c_side_ff;
   logic signed [FW-1:0] c_f_ff [3];
   logic signed [VW-1:0] c_xy_ff, c_xx_ff, c_zz_ff, c_yz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (en) begin
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c_side_ff <= b_side_ff;
         c_f_ff    <= b_f_ff;
         c_xy_ff   <= b_f_ff[0] * b_f_ff[1];
         c_xx_ff   <= b_f_ff[0] * b_f_ff[0];
         c_zz_ff   <= b_f_ff[2] * b_f_ff[2];
         c_yz_ff   <= b_f_ff[1] * b_f_ff[2];
      end
   end

   // stage D: select the vector of this row
   logic [VW-1:0] d_mag_in [3];
   logic [2:0]    d_neg_in;
   logic          d_valid_ff;
   side_type      d_side_ff;
   logic [VW-1:0] d_mag_ff [3];
   logic [2:0]    d_neg_ff;

   always_comb begin
      case (c_side_ff.row)
         ROW_RIGHT: begin
            d_mag_in[0] = abs_v(VW'(c_f_ff[2]));
            d_neg_in[0] = c_f_ff[2] < 0;
            d_mag_in[1] = '0;
            d_neg_in[1] = 1'b0;
            d_mag_in[2] = abs_v(VW'(c_f_ff[0]));
            d_neg_in[2] = c_f_ff[0] > 0;
         end
         ROW_UP: begin
            d_mag_in[0] = abs_v(c_xy_ff);
            d_neg_in[0] = c_xy_ff > 0;
            d_mag_in[1] = VW'(c_xx_ff + c_zz_ff);
            d_neg_in[1] = 1'b0;
            d_mag_in[2] = abs_v(c_yz_ff);
            d_neg_in[2] = c_yz_ff > 0;
         end
         default: begin
            for (int i = 0; i < 3; i++) begin
               d_mag_in[i] = abs_v(VW'(c_f_ff[i]));
               d_neg_in[i] = c_f_ff[i] < 0;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else if (en) begin
         d_valid_ff <= c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_side_ff <= c_side_ff;
         d_mag_ff  <= d_mag_in;
         d_neg_ff  <= d_neg_in;
      end
   end

   // stage E: leading one of the selected vector
   logic          e_valid_ff;
   side_type      e_side_ff;
   logic [VW-1:0] e_mag_ff [3];
   logic [2:0]    e_neg_ff;
   logic [5:0]    e_lead_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
      end else if (en) begin
         e_valid_ff <= d_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e_side_ff <= d_side_ff;
         e_mag_ff  <= d_mag_ff;
         e_neg_ff  <= d_neg_ff;
         e_lead_ff <= lead62(d_mag_ff[0] | d_mag_ff[1] | d_mag_ff[2]);
      end
   end

   // stage F: shift into range
   mag_type  f_mag_in [3];
   side_type f_side_in;
   logic     f_valid_ff;
   side_type f_side_ff;
   mag_type  f_mag_ff [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (e_lead_ff >= 6'd29) begin
            f_mag_in[i] = PM_W'(e_mag_ff[i] >> (e_lead_ff - 6'd29));
         end else begin
            f_mag_in[i] = PM_W'(e_mag_ff[i] << (6'd29 - e_lead_ff));
         end
      end
      f_side_in     = e_side_ff;
      f_side_in.neg = e_neg_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else if (en) begin
         f_valid_ff <= e_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f_side_ff <= f_side_in;
         f_mag_ff  <= f_mag_in;
      end
   end

   assign out_valid = f_valid_ff;
   assign out_side  = f_side_ff;
   assign out_mag   = f_mag_ff;

endmodule

FILE: src/lav_sqrt.sv
// Sum of squares and pipelined integer square root, two result bits a stage.
// Depends on lav_pkg.
`timescale 1ns / 1ps

module lav_sqrt (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  lav_pkg::side_type     in_side,
   input  lav_pkg::mag_type      in_mag [3],
   output logic                  out_valid,
   output lav_pkg::side_type     out_side,
   output lav_pkg::mag_type      out_mag [3],
   output logic [lav_pkg::RT_W-1:0] out_root
);
   import lav_pkg::*;

   localparam int ITERS = 32;
   localparam int PER   = 2;
   localparam int NST   = ITERS / PER;

   logic                g_valid_ff;
   side_type            g_side_ff;
   mag_type             g_mag_ff [3];
   logic [2*PM_W-1:0]   g_sq_ff [3];

   logic                valid_ff [NST+1];
   side_type            side_ff  [NST+1];
   mag_type             mag_ff   [NST+1][3];
   logic [SQ_W-1:0]     rem_ff   [NST+1];
   logic [SQ_W-1:0]     res_ff   [NST+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         g_valid_ff  <= 1'b0;
         valid_ff[0] <= 1'b0;
      end else if (en) begin
         g_valid_ff  <= in_valid;
         valid_ff[0] <= g_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         g_side_ff <= in_side;
         g_mag_ff  <= in_mag;
         for (int i = 0; i < 3; i++) begin
            g_sq_ff[i] <= in_mag[i] * in_mag[i];
         end
         side_ff[0] <= g_side_ff;
         mag_ff[0]  <= g_mag_ff;
         rem_ff[0]  <= SQ_W'(g_sq_ff[0]) + SQ_W'(g_sq_ff[1]) + SQ_W'(g_sq_ff[2]);
         res_ff[0]  <= '0;
      end
   end

   for (genvar g = 1; g <= NST; g++) begin : g_step
      logic [SQ_W-1:0] rem_in, res_in;

      always_comb begin
         logic [SQ_W-1:0] bitv;
         rem_in = rem_ff[g-1];
         res_in = res_ff[g-1];
         for (int j = 0; j < PER; j++) begin
            bitv = SQ_W'(1) << (62 - 2 * ((g - 1) * PER + j));
            if (rem_in >= res_in + bitv) begin
               rem_in = rem_in - (res_in + bitv);
               res_in = (res_in >> 1) + bitv;
            end else begin
               res_in = res_in >> 1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[g] <= 1'b0;
         end else if (en) begin
            valid_ff[g] <= valid_ff[g-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            side_ff[g] <= side_ff[g-1];
            mag_ff[g]  <= mag_ff[g-1];
            rem_ff[g]  <= rem_in;
            res_ff[g]  <= res_in;
         end
      end
   end

   assign out_valid = valid_ff[NST];
   assign out_side  = side_ff[NST];
   assign out_mag   = mag_ff[NST];
   assign out_root  = res_ff[NST][RT_W-1:0];

endmodule

FILE: src/lav_div.sv
// Three-lane pipelined restoring divider: rounded component over the norm,
// two quotient bits a stage. Depends on lav_pkg.
`timescale 1ns / 1ps

module lav_div #(
   parameter int FRAC_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  logic                      in_valid,
   input  lav_pkg::side_type         in_side,
   input  lav_pkg::mag_type          in_mag [3],
   input  logic [lav_pkg::RT_W-1:0]  in_root,
   output logic                      out_valid,
   output lav_pkg::side_type         out_side,
   output logic [FRAC_BITS:0]        out_quo [3]
);
   import lav_pkg::*;

   localparam int QW  = FRAC_BITS + 1;
   localparam int DW  = PM_W + FRAC_BITS + 1;
   localparam int PER = 2;
   localparam int NST = (QW + PER - 1) / PER;

   logic            valid_ff [NST+1];
   side_type        side_ff  [NST+1];
   logic [RT_W-1:0] den_ff   [NST+1];
   logic [RT_W-1:0] rem_ff   [NST+1][3];
   logic [QW-1:0]   low_ff   [NST+1][3];
   logic [QW-1:0]   quo_ff   [NST+1][3];

   logic [DW-1:0]   num_in [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         num_in[i] = (DW'(in_mag[i]) << FRAC_BITS) + DW'(in_root >> 1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= in_side;
         den_ff[0]  <= in_root;
         for (int i = 0; i < 3; i++) begin
            rem_ff[0][i] <= RT_W'(num_in[i] >> QW);
            low_ff[0][i] <= num_in[i][QW-1:0];
            quo_ff[0][i] <= '0;
         end
      end
   end

   for (genvar g = 1; g <= NST; g++) begin : g_step
      logic [RT_W-1:0] rem_in [3];
      logic [QW-1:0]   low_in [3];
      logic [QW-1:0]   quo_in [3];

      always_comb begin
         logic [RT_W:0] t;
         for (int i = 0; i < 3; i++) begin
            rem_in[i] = rem_ff[g-1][i];
            low_in[i] = low_ff[g-1][i];
            quo_in[i] = quo_ff[g-1][i];
            for (int j = 0; j < PER; j++) begin
               t = {rem_in[i], low_in[i][QW-1]};
               if ((g - 1) * PER + j < QW) begin
                  low_in[i] = low_in[i] << 1;
                  if (t >= {1'b0, den_ff[g-1]}) begin
                     rem_in[i] = RT_W'(t - {1'b0, den_ff[g-1]});
                     quo_in[i] = {quo_in[i][QW-2:0], 1'b1};
                  end else begin
                     rem_in[i] = RT_W'(t);
                     quo_in[i] = {quo_in[i][QW-2:0], 1'b0};
                  end
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[g] <= 1'b0;
         end else if (en) begin
            valid_ff[g] <= valid_ff[g-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            side_ff[g] <= side_ff[g-1];
            den_ff[g]  <= den_ff[g-1];
            rem_ff[g]  <= rem_in;
            low_ff[g]  <= low_in;
            quo_ff[g]  <= quo_in;
         end
      end
   end

   assign out_valid = valid_ff[NST];
   assign out_side  = side_ff[NST];
   assign out_quo   = quo_ff[NST];

endmodule

FILE: src/lav_out.sv
// Back pipeline: signed axis, dot with position, rounding, saturation and the
// result register. Depends on lav_pkg.
`timescale 1ns / 1ps

module lav_out #(
   parameter int FRAC_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en,
   input  logic                              in_valid,
   input  lav_pkg::side_type                 in_side,
   input  logic [FRAC_BITS:0]                in_quo [3],
   output logic                              out_valid,
   output lav_pkg::row_type                  out_row,
   output logic signed [lav_pkg::ELEM_W-1:0] out_elem [3],
   output logic signed [31:0]                out_trans,
   output logic                              out_last,
   output logic                              out_degen
);
   import lav_pkg::*;

   localparam int QW = FRAC_BITS + 1;
   localparam int AW = QW + 1;
   localparam int PW = AW + IN_W;
   localparam int SW = PW + 2;
   localparam logic [QW-1:0] ONE  = QW'(1) << FRAC_BITS;
   localparam logic [SW-1:0] HALF = SW'(1) << (FRAC_BITS - 1);
   localparam logic [SW-1:0] NEG_LIM = SW'(64'h8000_0000);
   localparam logic [SW-1:0] POS_LIM = SW'(64'h7FFF_FFFF);

   // stage 1: clamp and sign the axis
   logic [QW-1:0]        qc [3];
   logic signed [AW-1:0] a_in [3];
   logic                 s1_valid_ff;
   side_type             s1_side_ff;
   logic signed [AW-1:0] s1_a_ff [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         qc[i]   = (in_quo[i] > ONE) ? ONE : in_quo[i];
         a_in[i] = in_side.neg[i] ? -$signed({1'b0, qc[i]}) : $signed({1'b0, qc[i]});
      end
   end

   // stage 2: products with the position
   logic signed [IN_W-1:0] posv [3];
   logic                   s2_valid_ff;
   side_type               s2_side_ff;
   logic signed [AW-1:0]   s2_a_ff [3];
   logic signed [PW-1:0]   s2_p_ff [3];

   assign posv[0] = s1_side_ff.pos_x;
   assign posv[1] = s1_side_ff.pos_y;
   assign posv[2] = s1_side_ff.pos_z;

   // stage 3: sum
   logic                 s3_valid_ff;
   side_type             s3_side_ff;
   logic signed [AW-1:0] s3_a_ff [3];
   logic signed [SW-1:0] s3_acc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_side_ff <= in_side;
         s1_a_ff    <= a_in;
         s2_side_ff <= s1_side_ff;
         s2_a_ff    <= s1_a_ff;
         for (int i = 0; i < 3; i++) begin
            s2_p_ff[i] <= s1_a_ff[i] * posv[i];
         end
         s3_side_ff <= s2_side_ff;
         s3_a_ff    <= s2_a_ff;
         s3_acc_ff  <= SW'(s2_p_ff[0]) + SW'(s2_p_ff[1]) + SW'(s2_p_ff[2]);
      end
   end

   // stage 4: round, saturate and hold the result
   logic                 neg_t;
   logic [SW-1:0]        acc_mag, rnd, rnd_sat;
   logic signed [31:0]   trans_in;
   logic                 valid_ff;
   row_type              row_ff;
   logic signed [ELEM_W-1:0] elem_ff [3];
   logic signed [31:0]   trans_ff;
   logic                 last_ff;
   logic                 degen_ff;

   always_comb begin
      neg_t   = s3_acc_ff > 0;
      acc_mag = s3_acc_ff[SW-1] ? SW'(-s3_acc_ff) : SW'(s3_acc_ff);
      rnd     = (acc_mag + HALF) >> FRAC_BITS;
      if (neg_t) begin
         rnd_sat  = (rnd > NEG_LIM) ? NEG_LIM : rnd;
         trans_in = 32'(-rnd_sat);
      end else begin
         rnd_sat  = (rnd > POS_LIM) ? POS_LIM : rnd;
         trans_in = 32'(rnd_sat);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         row_ff   <= s3_side_ff.row;
         last_ff  <= s3_side_ff.row == ROW_FWD;
         degen_ff <= s3_side_ff.degen;
         trans_ff <= s3_side_ff.degen ? '0 : trans_in;
         for (int i = 0; i < 3; i++) begin
            elem_ff[i] <= s3_side_ff.degen ? '0 : ELEM_W'(s3_a_ff[i]);
         end
      end
   end

   assign out_valid = valid_ff;
   assign out_row   = row_ff;
   assign out_elem  = elem_ff;
   assign out_trans = trans_ff;
   assign out_last  = last_ff;
   assign out_degen = degen_ff;

endmodule

FILE: src/look_at_view_matrix_top.sv
// Top level of the look-at view matrix builder: input holder, row issue and the
// row pipeline. Depends on lav_pkg, lav_prep, lav_sqrt, lav_div and lav_out.
`timescale 1ns / 1ps
//
// Usage
//   req channel: one beat carries a camera position and a viewing vector,
//   six signed fixed-point words with FRAC_BITS fraction bits.
//   rsp channel: three beats per request, rows right, up and forward, each
//   with three axis components and the negated, rounded and saturated dot
//   of the axis with the position. tlast marks the forward row; tuser holds
//   the row index and a degenerate flag (view zero or along world up, rows
//   then carry zero data).
//   Throughput: the row pipeline takes one row per cycle unless rsp stalls,
//   and each request feeds it three rows from the input holder.
//   Path: the input holder issues each row into the front pipeline, the
//   square root stages (two bits each), the divider stages and the back
//   pipeline.
//   Reset: synchronous, clears all valid bits; no result is pending after it.
//   Stall: while rsp_tready is low and a row waits, the whole pipeline holds;
//   the holder still takes one new request if it is empty.
//
module look_at_view_matrix_top #(
   parameter int FRAC_BITS = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // pos_x, pos_y, pos_z, view_x, view_y, view_z (32 bits each)
   input  logic [191:0]  req_tdata,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // elem_0 (18), elem_1 (18), elem_2 (18), elem_3 (32), zero pad (2)
   output logic [87:0]   rsp_tdata,
   // row_index (2), degenerate (1)
   output logic [2:0]    rsp_tuser,
   output logic          rsp_tlast
);
   import lav_pkg::*;

   logic        en;
   logic        req_beat;
   logic        hold_valid_ff;
   logic [191:0] hold_data_ff;
   row_type     row_ff, row_in;
   side_type    issue_side;

   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = !hold_valid_ff || (en && row_ff == ROW_FWD);
   assign req_beat   = req_tvalid && req_tready;

   always_comb begin
      case (row_ff)
         ROW_RIGHT: row_in = ROW_UP;
         ROW_UP:    row_in = ROW_FWD;
         default:   row_in = ROW_RIGHT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         row_ff        <= ROW_RIGHT;
      end else if (req_beat) begin
         hold_valid_ff <= 1'b1;
         row_ff        <= ROW_RIGHT;
      end else if (en && hold_valid_ff) begin
         row_ff <= row_in;
         if (row_ff == ROW_FWD) begin
            hold_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat) begin
         hold_data_ff <= req_tdata;
      end
   end

   always_comb begin
      issue_side       = '0;
      issue_side.row   = row_ff;
      issue_side.pos_x = hold_data_ff[31:0];
      issue_side.pos_y = hold_data_ff[63:32];
      issue_side.pos_z = hold_data_ff[95:64];
   end

   logic     p_valid;
   side_type p_side;
   mag_type  p_mag [3];

   lav_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (hold_valid_ff),
      .in_side   (issue_side),
      .view_x    (hold_data_ff[127:96]),
      .view_y    (hold_data_ff[159:128]),
      .view_z    (hold_data_ff[191:160]),
      .out_valid (p_valid),
      .out_side  (p_side),
      .out_mag   (p_mag)
   );

   logic            s_valid;
   side_type        s_side;
   mag_type         s_mag [3];
   logic [RT_W-1:0] s_root;

   lav_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (p_valid),
      .in_side   (p_side),
      .in_mag    (p_mag),
      .out_valid (s_valid),
      .out_side  (s_side),
      .out_mag   (s_mag),
      .out_root  (s_root)
   );

   logic             d_valid;
   side_type         d_side;
   logic [FRAC_BITS:0] d_quo [3];

   lav_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s_valid),
      .in_side   (s_side),
      .in_mag    (s_mag),
      .in_root   (s_root),
      .out_valid (d_valid),
      .out_side  (d_side),
      .out_quo   (d_quo)
   );

   row_type                  o_row;
   logic signed [ELEM_W-1:0] o_elem [3];
   logic signed [31:0]       o_trans;
   logic                     o_degen;

   lav_out #(.FRAC_BITS(FRAC_BITS)) u_out (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (d_valid),
      .in_side   (d_side),
      .in_quo    (d_quo),
      .out_valid (rsp_tvalid),
      .out_row   (o_row),
      .out_elem  (o_elem),
      .out_trans (o_trans),
      .out_last  (rsp_tlast),
      .out_degen (o_degen)
   );

   assign rsp_tdata = {2'b00, o_trans, o_elem[2], o_elem[1], o_elem[0]};
   assign rsp_tuser = {o_degen, o_row};

`ifndef SYNTH
   a_last_is_fwd: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tuser[1:0] == ROW_FWD)))
      else $error("tlast does not match the forward row");

   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[2] |-> rsp_tdata == '0)
      else $error("degenerate row carries data");

   a_hold_busy: assert property (@(posedge clock) disable iff (reset)
      hold_valid_ff && row_ff != ROW_FWD |-> !req_tready)
      else $error("request taken while rows are still being issued");

   a_accept_row: assert property (@(posedge clock) disable iff (reset)
      req_beat |=> hold_valid_ff && row_ff == ROW_RIGHT)
      else $error("accepted request does not start at the right row");
`endif

endmodule

FILE: dv/tb.sv
// Testbench for look_at_view_matrix_top: drives camera position and view beats,
// predicts the three view-matrix rows per beat and checks every rsp beat.
// Depends on lav_pkg and the look_at_view_matrix_top RTL.
`timescale 1ns / 1ps

module tb;
   import lav_pkg::*;

   localparam int FRAC = 16;
   localparam int LATENCY = 29 + (FRAC + 2) / 2;

   typedef struct packed {
      logic [1:0]  row;
      logic [17:0] e0;
      logic [17:0] e1;
      logic [17:0] e2;
      logic [31:0] e3;
      logic        last;
      logic        degen;
   } row_beat_type;

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [191:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [87:0]  rsp_tdata;
   logic [2:0]   rsp_tuser;
   logic         rsp_tlast;

   row_beat_type rows_due[$];
   int           mismatches = 0;
   int           burst_left = 0;
   bit           no_gaps = 0;

   look_at_view_matrix_top #(.FRAC_BITS(FRAC)) u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   initial begin
      #20ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   function automatic logic [63:0] mag_of(input logic signed [63:0] v);
      return v < 0 ? -v : v;
   endfunction

   function automatic void scale_vec(input logic signed [63:0] a[3],
                                     output logic signed [63:0] b[3]);
      logic [63:0] m[3];
      logic [63:0] mx;
      mx = 0;
      for (int i = 0; i < 3; i++) begin
         m[i] = mag_of(a[i]);
         if (m[i] > mx) mx = m[i];
      end
      if (mx != 0) begin
         while (mx >= 64'd1 << 30) begin
            mx >>= 1;
            for (int i = 0; i < 3; i++) m[i] >>= 1;
         end
         while (mx < 64'd1 << 29) begin
            mx <<= 1;
            for (int i = 0; i < 3; i++) m[i] <<= 1;
         end
      end
      for (int i = 0; i < 3; i++) b[i] = a[i] < 0 ? -$signed(m[i]) : $signed(m[i]);
   endfunction

   function automatic logic [63:0] int_sqrt(input logic [63:0] s);
      logic [63:0] res;
      logic [63:0] bt;
      res = 0;
      bt = 64'd1 << 62;
      while (bt > s) bt >>= 2;
      while (bt != 0) begin
         if (s >= res + bt) begin
            s = s - (res + bt);
            res = (res >> 1) + bt;
         end else begin
            res >>= 1;
         end
         bt >>= 2;
      end
      return res;
   endfunction

   function automatic void unit_axis(input logic signed [63:0] a[3],
                                     output logic signed [63:0] u[3]);
      logic signed [63:0] p[3];
      logic [63:0] m[3];
      logic [63:0] s;
      logic [63:0] n;
      logic [63:0] q;
      scale_vec(a, p);
      s = 0;
      for (int i = 0; i < 3; i++) begin
         m[i] = mag_of(p[i]);
         s += m[i] * m[i];
      end
      n = int_sqrt(s);
      for (int i = 0; i < 3; i++) begin
         q = 0;
         if (n != 0) begin
            q = ((m[i] << FRAC) + (n >> 1)) / n;
            if (q > (64'd1 << FRAC)) q = 64'd1 << FRAC;
         end
         u[i] = p[i] < 0 ? -$signed(q) : $signed(q);
      end
   endfunction

   function automatic logic [31:0] translate(input logic signed [63:0] a[3],
                                             input logic signed [63:0] p[3]);
      logic signed [63:0] acc;
      logic [63:0] r;
      acc = a[0] * p[0] + a[1] * p[1] + a[2] * p[2];
      r = (mag_of(acc) + (64'd1 << (FRAC - 1))) >> FRAC;
      if (acc > 0) begin
         if (r > 64'h8000_0000) r = 64'h8000_0000;
         return 32'(-$signed(r));
      end
      if (r > 64'h7FFF_FFFF) r = 64'h7FFF_FFFF;
      return 32'(r);
   endfunction

   task automatic predict_rows(input logic [191:0] d);
      logic signed [63:0] pos[3], nv[3], f[3], r[3], u[3];
      logic signed [63:0] ax[3][3];
      logic degen;
      row_beat_type b;
      for (int i = 0; i < 3; i++) begin
         pos[i] = $signed(d[32*i +: 32]);
         nv[i] = -$signed({{32{d[32*(i+3)+31]}}, d[32*(i+3) +: 32]});
      end
      scale_vec(nv, f);
      degen = (f[0] == 0 && f[2] == 0);
      for (int k = 0; k < 3; k++) for (int i = 0; i < 3; i++) ax[k][i] = 0;
      if (!degen) begin
         r[0] = f[2]; r[1] = 0; r[2] = -f[0];
         u[0] = -(f[0] * f[1]);
         u[1] = f[0] * f[0] + f[2] * f[2];
         u[2] = -(f[1] * f[2]);
         unit_axis(r, ax[0]);
         unit_axis(u, ax[1]);
         unit_axis(f, ax[2]);
      end
      for (int k = 0; k < 3; k++) begin
         b.row = row_type'(k);
         b.e0 = ax[k][0][17:0];
         b.e1 = ax[k][1][17:0];
         b.e2 = ax[k][2][17:0];
         b.e3 = degen ? 32'd0 : translate(ax[k], pos);
         b.last = (row_type'(k) == ROW_FWD);
         b.degen = degen;
         rows_due = {rows_due, b};
      end
   endtask

   task automatic send_view(input logic [191:0] d);
      int gap;
      if (!no_gaps) begin
         if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
               req_tvalid <= 0;
               repeat (gap) @(posedge clock);
            end
            burst_left = $urandom_range(1, 12);
         end
         burst_left--;
      end
      req_tvalid <= 1;
      req_tdata <= d;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_rows(d);
   endtask

   function automatic logic [191:0] pack_view(input logic [31:0] px, py, pz, vx, vy, vz);
      return {vz, vy, vx, pz, py, px};
   endfunction

   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'($signed($urandom_range(0, 8)) - 4);
         3: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
         default: return $urandom;
      endcase
   endfunction

   // receiver stall pattern
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 0;
      end else begin
         rsp_tready <= ($urandom_range(0, 9) < 7) || no_gaps;
      end
   end

   always @(posedge clock) begin
      row_beat_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tuser[1:0], rsp_tdata[17:0], rsp_tdata[35:18], rsp_tdata[53:36],
                rsp_tdata[85:54], rsp_tlast, rsp_tuser[2]};
         if (rows_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected beat %h", got);
         end else begin
            want = rows_due.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %h actual %h", want, got);
            end
         end
      end
   end

   task automatic wait_drained();
      req_tvalid <= 0;
      while (rows_due.size() != 0) @(posedge clock);
   endtask

   task automatic test_extremes();
      send_view(pack_view(0, 0, 0, 0, 0, 32'hFFFF_0000));
      send_view(pack_view(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                          32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
      send_view(pack_view(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                          32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
      send_view(pack_view(32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 1, 1, 1));
      send_view(pack_view(32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
                          32'h0001_0000, 0, 0));
      send_view(pack_view(5, 6, 7, 0, 32'h8000_0000, 1));
   endtask

   task automatic test_degenerate();
      send_view(pack_view(1, 2, 3, 0, 0, 0));
      send_view(pack_view(32'h7FFF_FFFF, 0, 0, 0, 32'h0001_0000, 0));
      send_view(pack_view(0, 32'h8000_0000, 0, 0, 32'h8000_0000, 0));
      send_view(pack_view(9, 9, 9, 0, 32'h7FFF_FFFF, 0));
      send_view(pack_view(1, 1, 1, 1, 32'h7FFF_FFFF, 0));
   endtask

   task automatic test_back_to_back();
      no_gaps = 1;
      for (int i = 0; i < 10; i++)
         send_view(pack_view(rand_word(), rand_word(), rand_word(),
                             rand_word(), rand_word(), rand_word()));
      no_gaps = 0;
      wait_drained();
   endtask

   task automatic test_random();
      for (int i = 0; i < 470; i++) begin
         if ($urandom_range(0, 19) == 0)
            send_view(pack_view(rand_word(), rand_word(), rand_word(),
                                0, rand_word(), 0));
         else
            send_view(pack_view(rand_word(), rand_word(), rand_word(),
                                rand_word(), rand_word(), rand_word()));
         if (i == 200) wait_drained();
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_extremes();
      test_degenerate();
      test_back_to_back();
      test_random();
      wait_drained();
      repeat (LATENCY + 10) @(posedge clock);
      if (mismatches == 0 && rows_due.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end
endmodule

FILE: look_at_view_matrix_top.f
src/lav_pkg.sv
src/lav_prep.sv
src/lav_sqrt.sv
src/lav_div.sv
src/lav_out.sv
src/look_at_view_matrix_top.sv
dv/tb.sv
